/* hdl/tdfd_pkg.sv */
// shared types and constants for the toggle delta frame decoder
package tdfd_pkg;

   localparam int FRAME_COLS_DEF = 90;
   localparam int FRAME_ROWS_DEF = 68;

   localparam int BYTE_W   = 8;
   localparam int WORD_W   = 16;
   localparam int COUNT_W  = 15;
   localparam int DIV_BITS = 4;

   localparam logic [BYTE_W-1:0] DISPLAY_COLS_RST = 8'd40;
   localparam logic [BYTE_W-1:0] DISPLAY_ROWS_RST = 8'd19;

   localparam logic CSR_DISPLAY_COLS = 1'b0;
   localparam logic CSR_DISPLAY_ROWS = 1'b1;

   localparam logic ACT_STREAM = 1'b0;
   localparam logic ACT_READ   = 1'b1;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_ODD    = 2'd1;
   localparam logic [1:0] STATUS_RANGE  = 2'd2;
   localparam logic [1:0] STATUS_HALTED = 2'd3;

   localparam logic [1:0] PH_LEN_LO = 2'd0;
   localparam logic [1:0] PH_LEN_HI = 2'd1;
   localparam logic [1:0] PH_POS_LO = 2'd2;
   localparam logic [1:0] PH_POS_HI = 2'd3;

   typedef struct packed {
      logic              action;
      logic [BYTE_W-1:0] stream_byte;
      logic [BYTE_W-1:0] cell_col;
      logic [BYTE_W-1:0] cell_row;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       frame_done;
      logic       pixel_lit;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
   } scale_ctl_type;

endpackage

/* hdl/tdfd_ram.sv */
// generic single write, single read ram with registered read data
module tdfd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/tdfd_scale.sv */
// iterative nearest-neighbour scaler: floor((cell+1)*span/size)-1, clamped
module tdfd_scale import tdfd_pkg::*; #(
   parameter int SPAN = FRAME_COLS_DEF,
   localparam int IDX_W = (SPAN > 1) ? $clog2(SPAN) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  scale_ctl_type     ctl_in,
   output scale_ctl_type     ctl_out,
   input  logic [BYTE_W-1:0] cell_num,
   input  logic [BYTE_W-1:0] size,
   output logic [IDX_W-1:0]  index
);

   localparam int SPAN_W = $clog2(SPAN + 1);
   localparam int NUM_W  = BYTE_W + 1 + SPAN_W;
   localparam int STEPS  = (NUM_W + DIV_BITS - 1) / DIV_BITS;
   localparam int PAD_W  = STEPS * DIV_BITS;
   localparam int CNT_W  = $clog2(STEPS + 1);
   localparam logic [PAD_W-1:0] LAST_IDX = PAD_W'(SPAN - 1);

   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [PAD_W-1:0]  num_ff, num_in;
   logic [PAD_W-1:0]  quo_ff, quo_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [BYTE_W-1:0] div_ff, div_in;
   logic [PAD_W-1:0]  quo_dec;

   always_comb begin
      logic [BYTE_W:0]  t;
      logic [BYTE_W-1:0] r;
      logic [PAD_W-1:0] n;
      logic [PAD_W-1:0] q;
      cnt_in = cnt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      r = rem_ff;
      n = num_ff;
      q = quo_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         t = {r, n[PAD_W-1]};
         n = {n[PAD_W-2:0], 1'b0};
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
            q = {q[PAD_W-2:0], 1'b1};
         end else begin
            q = {q[PAD_W-2:0], 1'b0};
         end
         r = t[BYTE_W-1:0];
      end
      if (ctl_in.start) begin
         num_in = PAD_W'((32'(cell_num) + 32'd1) * SPAN);
         div_in = (size == '0) ? BYTE_W'(1) : size;
         rem_in = '0;
         quo_in = '0;
         cnt_in = CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         num_in = n;
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quo_dec = (quo_ff == '0) ? '0 : quo_ff - PAD_W'(1);
   assign index   = (quo_dec > LAST_IDX) ? LAST_IDX[IDX_W-1:0] : quo_dec[IDX_W-1:0];

   assign ctl_out.start = 1'b0;
   assign ctl_out.busy  = (cnt_ff != '0);

endmodule

/* hdl/toggle_delta_frame_decoder_top.sv */
// toggle delta frame decoder: stream parser, bitmap ram and scaled pixel reads
// path: a stream byte goes to ST_RESP; a position toggle reads the ram on acceptance, writes it back in ST_TOGGLE,
//   then ST_RESP; a display read waits in ST_SCALE for both scalers, then ST_READ, ST_LOOK and ST_RESP
// throughput: one transaction at a time, next accepted once the result is registered
// after reset the bitmap ram is cleared one pixel a cycle, all FRAME_COLS*FRAME_ROWS pixels
//   (6120 at 90x68), with req_ready low; csr writes are taken throughout
module toggle_delta_frame_decoder_top import tdfd_pkg::*; #(
   parameter int FRAME_COLS = FRAME_COLS_DEF,
   parameter int FRAME_ROWS = FRAME_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata
);

   localparam int MAP_SIZE = FRAME_COLS * FRAME_ROWS;
   localparam int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;
   localparam int COL_W    = (FRAME_COLS > 1) ? $clog2(FRAME_COLS) : 1;
   localparam int ROW_W    = (FRAME_ROWS > 1) ? $clog2(FRAME_ROWS) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_SIZE - 1);
   localparam logic [WORD_W:0]   MAP_LIMIT = (WORD_W + 1)'(MAP_SIZE);

   typedef enum logic [6:0] {
      ST_CLEAR  = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_SCALE  = 7'b0000100,
      ST_READ   = 7'b0001000,
      ST_LOOK   = 7'b0010000,
      ST_TOGGLE = 7'b0100000,
      ST_RESP   = 7'b1000000
   } state_type;

   state_type          state_ff, state_in;
   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0]  low_ff, low_in;
   logic               halted_ff, halted_in;
   logic [BYTE_W-1:0]  cols_ff, cols_in;
   logic [BYTE_W-1:0]  rows_ff, rows_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   rsp_type            pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic [WORD_W-1:0]  word;
   logic [COUNT_W-1:0] left_dec;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               wr_data;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_data;
   scale_ctl_type      col_ctl_in, col_ctl_out;
   scale_ctl_type      row_ctl_in, row_ctl_out;
   logic [COL_W-1:0]   col_idx;
   logic [ROW_W-1:0]   row_idx;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign word       = {req_data.stream_byte, low_ff};
   assign left_dec   = (left_ff != '0) ? left_ff - COUNT_W'(1) : '0;

   assign col_ctl_in.start = req_accept && (req_data.action == ACT_READ);
   assign col_ctl_in.busy  = 1'b0;
   assign row_ctl_in.start = req_accept && (req_data.action == ACT_READ);
   assign row_ctl_in.busy  = 1'b0;

   tdfd_scale #(
      .SPAN (FRAME_COLS)
   ) u_scale_col (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (col_ctl_in),
      .ctl_out  (col_ctl_out),
      .cell_num (req_data.cell_col),
      .size     (cols_ff),
      .index    (col_idx)
   );

   tdfd_scale #(
      .SPAN (FRAME_ROWS)
   ) u_scale_row (
      .clock    (clock),
      .reset    (reset),
      .ctl_in   (row_ctl_in),
      .ctl_out  (row_ctl_out),
      .cell_num (req_data.cell_row),
      .size     (rows_ff),
      .index    (row_idx)
   );

   tdfd_ram #(
      .WIDTH (1),
      .DEPTH (MAP_SIZE)
   ) u_pixel_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DISPLAY_COLS: cols_in = csr_wdata;
            CSR_DISPLAY_ROWS: rows_in = csr_wdata;
            default:          cols_in = cols_ff;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      left_in      = left_ff;
      low_in       = low_ff;
      halted_in    = halted_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = ~rd_data;
      rd_en        = 1'b0;
      rd_addr      = addr_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 1'b0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               pend_in  = '0;
               state_in = ST_RESP;
               if (req_data.action == ACT_READ) begin
                  pend_in.status = halted_ff ? STATUS_HALTED : STATUS_OK;
                  state_in       = ST_SCALE;
               end else if (halted_ff) begin
                  pend_in.status = STATUS_HALTED;
               end else begin
                  case (phase_ff)
                     PH_LEN_LO: begin
                        low_in   = req_data.stream_byte;
                        phase_in = PH_LEN_HI;
                     end
                     PH_LEN_HI: begin
                        if (word[0]) begin
                           pend_in.status = STATUS_ODD;
                           halted_in      = 1'b1;
                           phase_in       = PH_LEN_LO;
                        end else if (word == '0) begin
                           pend_in.frame_done = 1'b1;
                           phase_in           = PH_LEN_LO;
                        end else begin
                           left_in  = word[WORD_W-1:1];
                           phase_in = PH_POS_LO;
                        end
                     end
                     PH_POS_LO: begin
                        low_in   = req_data.stream_byte;
                        phase_in = PH_POS_HI;
                     end
                     default: begin
                        if ({1'b0, word} < MAP_LIMIT) begin
                           rd_en    = 1'b1;
                           rd_addr  = word[ADDR_W-1:0];
                           addr_in  = word[ADDR_W-1:0];
                           state_in = ST_TOGGLE;
                        end else begin
                           pend_in.status = STATUS_RANGE;
                        end
                        left_in = left_dec;
                        if (left_dec == '0) begin
                           pend_in.frame_done = 1'b1;
                           phase_in           = PH_LEN_LO;
                        end else begin
                           phase_in = PH_POS_LO;
                        end
                     end
                  endcase
               end
            end
         end
         ST_SCALE: begin
            if (!col_ctl_out.busy && !row_ctl_out.busy) begin
               addr_in  = ADDR_W'(32'(row_idx) * FRAME_COLS + 32'(col_idx));
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_LOOK;
         end
         ST_LOOK: begin
            pend_in.pixel_lit = rd_data;
            state_in          = ST_RESP;
         end
         ST_TOGGLE: begin
            wr_en    = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_LEN_LO;
         left_ff      <= '0;
         low_ff       <= '0;
         halted_ff    <= 1'b0;
         cols_ff      <= DISPLAY_COLS_RST;
         rows_ff      <= DISPLAY_ROWS_RST;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         left_ff      <= left_in;
         low_ff       <= low_in;
         halted_ff    <= halted_in;
         cols_ff      <= cols_in;
         rows_ff      <= rows_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/tdfd_checker.sv */
// port level checks for the toggle delta frame decoder, bound to the top level
module tdfd_checker import tdfd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp transaction changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.frame_done && rsp_data.pixel_lit))
      else $error("rsp has both frame_done and pixel_lit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_ODD) |-> !rsp_data.frame_done)
      else $error("odd length reported with frame_done");

   // bitmap clear keeps the block closed right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("activity right after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second transaction accepted back to back");

endmodule

bind toggle_delta_frame_decoder_top tdfd_checker u_tdfd_checker (.*);

/* tb/sv/toggle_delta_frame_decoder_checker.sv */
// bitmap decode predictor and result comparison for the frame decoder testbench
module toggle_delta_frame_decoder_checker import tdfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  req_type           req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rsp_type           rsp_data,
   input  logic              csr_write_en,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata,
   output int                pending,
   output int                failures
);

   localparam int MAP_PIXELS = FRAME_COLS_DEF * FRAME_ROWS_DEF;

   bit                 lit_map [MAP_PIXELS];
   logic [1:0]         phase;
   logic [COUNT_W-1:0] updates_left;
   logic [BYTE_W-1:0]  low_hold;
   logic               halted;
   logic [BYTE_W-1:0]  cols_cfg;
   logic [BYTE_W-1:0]  rows_cfg;
   rsp_type            expected_q [$];

   function automatic int unsigned nearest_index(input int unsigned cell_num,
                                                 input int unsigned size,
                                                 input int unsigned span);
      int unsigned divisor;
      int unsigned v;
      divisor = (size == 0) ? 1 : size;
      v = ((cell_num + 1) * span) / divisor;
      v = (v == 0) ? 0 : v - 1;
      if (v > span - 1) v = span - 1;
      return v;
   endfunction

   function automatic rsp_type decode_transaction(input req_type item);
      rsp_type           r;
      logic [WORD_W-1:0] word;
      int unsigned       ix;
      int unsigned       iy;
      r    = '0;
      word = {item.stream_byte, low_hold};
      if (item.action == ACT_READ) begin
         ix          = nearest_index(32'(item.cell_col), 32'(cols_cfg), FRAME_COLS_DEF);
         iy          = nearest_index(32'(item.cell_row), 32'(rows_cfg), FRAME_ROWS_DEF);
         r.pixel_lit = lit_map[iy * FRAME_COLS_DEF + ix];
         r.status    = halted ? STATUS_HALTED : STATUS_OK;
      end else if (halted) begin
         r.status = STATUS_HALTED;
      end else begin
         case (phase)
            PH_LEN_LO: begin
               low_hold = item.stream_byte;
               phase    = PH_LEN_HI;
            end
            PH_LEN_HI: begin
               if (word[0]) begin
                  r.status = STATUS_ODD;
                  halted   = 1'b1;
                  phase    = PH_LEN_LO;
               end else if (word == 0) begin
                  r.frame_done = 1'b1;
                  phase        = PH_LEN_LO;
               end else begin
                  updates_left = word[WORD_W-1:1];
                  phase        = PH_POS_LO;
               end
            end
            PH_POS_LO: begin
               low_hold = item.stream_byte;
               phase    = PH_POS_HI;
            end
            default: begin
               if (word < MAP_PIXELS) lit_map[word] = ~lit_map[word];
               else r.status = STATUS_RANGE;
               if (updates_left != 0) updates_left = updates_left - 1'b1;
               if (updates_left == 0) begin
                  r.frame_done = 1'b1;
                  phase        = PH_LEN_LO;
               end else begin
                  phase = PH_POS_LO;
               end
            end
         endcase
      end
      return r;
   endfunction

   // sampled mid-cycle: these are the values the next rising edge acts on
   always @(negedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (lit_map[i]) lit_map[i] = 1'b0;
         phase        = PH_LEN_LO;
         updates_left = '0;
         low_hold     = '0;
         halted       = 1'b0;
         cols_cfg     = DISPLAY_COLS_RST;
         rows_cfg     = DISPLAY_ROWS_RST;
         expected_q.delete();
      end else begin
         if (csr_write_en) begin
            if (csr_index == CSR_DISPLAY_COLS) cols_cfg = csr_wdata;
            else rows_cfg = csr_wdata;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("rsp_data: transaction with none expected, actual %p", rsp_data);
               failures++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.frame_done !== want.frame_done) begin
                  $error("frame_done: expected %0d, actual %0d",
                         want.frame_done, rsp_data.frame_done);
                  failures++;
               end
               if (rsp_data.pixel_lit !== want.pixel_lit) begin
                  $error("pixel_lit: expected %0d, actual %0d",
                         want.pixel_lit, rsp_data.pixel_lit);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready) expected_q.push_back(decode_transaction(req_data));
      end
      pending = expected_q.size();
   end

endmodule

/* tb/sv/toggle_delta_frame_decoder_top_tb.sv */
// stimulus and verdict for the toggle delta frame decoder testbench
module toggle_delta_frame_decoder_top_tb;
   import tdfd_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_write_en;
   logic              csr_index;
   logic [BYTE_W-1:0] csr_wdata;

   int pending;
   int failures;
   bit req_steady;
   bit rsp_steady;
   bit mix_reads;
   int n_bytes;
   int n_reads;
   int n_frames;
   int n_settings;

   toggle_delta_frame_decoder_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   toggle_delta_frame_decoder_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .pending      (pending),
      .failures     (failures)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #4_000_000;
      $display("toggle_delta_frame_decoder_top_tb: errors");
      $finish;
   end

   // result side back-pressure
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = rsp_steady ? 0 : int'($urandom_range(0, 15));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(negedge clock); while (!rsp_valid);
         @(posedge clock);
      end
   end

   task automatic send_item(input req_type item);
      int gap;
      gap = req_steady ? 0 : int'($urandom_range(0, 15));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      if (item.action == ACT_READ) n_reads++;
      else n_bytes++;
   endtask

   task automatic feed_byte(input logic [BYTE_W-1:0] b);
      req_type item;
      item.action      = ACT_STREAM;
      item.stream_byte = b;
      item.cell_col    = BYTE_W'($urandom_range(0, 254));
      item.cell_row    = BYTE_W'($urandom_range(0, 254));
      send_item(item);
   endtask

   task automatic read_cell(input logic [BYTE_W-1:0] col, input logic [BYTE_W-1:0] row);
      req_type item;
      item.action      = ACT_READ;
      item.stream_byte = BYTE_W'($urandom_range(0, 255));
      item.cell_col    = col;
      item.cell_row    = row;
      send_item(item);
   endtask

   function automatic logic [BYTE_W-1:0] random_cell();
      int unsigned pick;
      pick = $urandom_range(0, 4);
      if (pick < 2) return BYTE_W'($urandom_range(0, 15));
      else if (pick == 2) return BYTE_W'($urandom_range(230, 254));
      else return BYTE_W'($urandom_range(0, 254));
   endfunction

   // toggles cluster in two corners so that scaled reads often land on lit pixels
   function automatic logic [WORD_W-1:0] random_position();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 4)
         return WORD_W'($urandom_range(0, 7) * FRAME_COLS_DEF + $urandom_range(0, 9));
      else if (pick < 6)
         return WORD_W'($urandom_range(FRAME_ROWS_DEF - 8, FRAME_ROWS_DEF - 1) * FRAME_COLS_DEF
                + $urandom_range(FRAME_COLS_DEF - 10, FRAME_COLS_DEF - 1));
      else if (pick < 9)
         return WORD_W'($urandom_range(0, FRAME_COLS_DEF * FRAME_ROWS_DEF - 1));
      else
         return WORD_W'($urandom_range(FRAME_COLS_DEF * FRAME_ROWS_DEF, 65535));
   endfunction

   task automatic send_word(input logic [WORD_W-1:0] w);
      feed_byte(w[7:0]);
      if (mix_reads && $urandom_range(0, 4) == 0) read_cell(random_cell(), random_cell());
      feed_byte(w[15:8]);
   endtask

   task automatic send_frame(input int n);
      send_word(WORD_W'(2 * n));
      for (int k = 0; k < n; k++) send_word(random_position());
      n_frames++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_display(input logic [BYTE_W-1:0] cols, input logic [BYTE_W-1:0] rows);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_DISPLAY_COLS;
      csr_wdata    <= cols;
      @(posedge clock);
      csr_index    <= CSR_DISPLAY_ROWS;
      csr_wdata    <= rows;
      @(posedge clock);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   initial begin
      int start;
      int pick;
      logic [BYTE_W-1:0] cols;
      logic [BYTE_W-1:0] rows;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_data     <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= CSR_DISPLAY_COLS;
      csr_wdata    <= '0;
      req_steady   = 1'b0;
      rsp_steady   = 1'b0;
      mix_reads    = 1'b0;
      n_bytes      = 0;
      n_reads      = 0;
      n_frames     = 0;
      n_settings   = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset display size, blank bitmap, corner cells
      read_cell(8'd0, 8'd0);
      read_cell(8'd254, 8'd254);
      // empty frame
      send_word(16'h0000);
      n_frames++;
      // first and last pixel, then an off-map position ending the frame
      send_word(16'd6);
      send_word(16'd0);
      send_word(WORD_W'(FRAME_COLS_DEF * FRAME_ROWS_DEF - 1));
      send_word(WORD_W'(FRAME_COLS_DEF * FRAME_ROWS_DEF));
      n_frames++;
      send_word(16'd2);
      send_word(16'hFFFF);
      n_frames++;

      drain_results();
      write_display(8'd255, 8'd255);
      read_cell(8'd0, 8'd0);
      read_cell(8'd254, 8'd254);
      // zero display size acts as one
      drain_results();
      write_display(8'd0, 8'd0);
      read_cell(8'd0, 8'd0);
      read_cell(8'd254, 8'd0);
      drain_results();
      write_display(8'd1, 8'd1);
      read_cell(8'd0, 8'd0);

      mix_reads = 1'b1;
      for (int p = 0; p < 6; p++) begin
         drain_results();
         case (p)
            0: begin cols = 8'd90;  rows = 8'd68;  end
            1: begin cols = 8'd255; rows = 8'd1;   end
            2: begin cols = 8'd1;   rows = 8'd255; end
            4: begin cols = 8'd40;  rows = 8'd19;  end
            default: begin
               cols = BYTE_W'($urandom_range(1, 255));
               rows = BYTE_W'($urandom_range(1, 255));
            end
         endcase
         write_display(cols, rows);
         start = n_bytes + n_reads;
         while (n_bytes + n_reads - start < 115) begin
            req_steady = ($urandom_range(0, 3) == 0);
            rsp_steady = ($urandom_range(0, 3) == 0);
            pick = int'($urandom_range(0, 9));
            if (pick == 0) send_frame(0);
            else if (pick == 1) send_frame(int'($urandom_range(15, 30)));
            else if (pick < 4) repeat ($urandom_range(1, 4)) read_cell(random_cell(), random_cell());
            else send_frame(int'($urandom_range(1, 6)));
         end
      end

      // odd length halts the parser for the rest of the run
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      send_word({8'($urandom_range(0, 255)), 8'($urandom_range(0, 127) * 2 + 1)});
      repeat (12) begin
         if ($urandom_range(0, 1) == 0) feed_byte(BYTE_W'($urandom_range(0, 255)));
         else read_cell(random_cell(), random_cell());
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("covered %0d stream bytes in %0d frames and %0d display reads",
               n_bytes, n_frames, n_reads);
      $display("over %0d display sizes, ending with a halt on an odd frame length",
               n_settings);
      if (failures == 0) $display("toggle_delta_frame_decoder_top_tb: clean");
      else $display("toggle_delta_frame_decoder_top_tb: errors");
      $finish;
   end

endmodule

/* files.f */
hdl/tdfd_pkg.sv
hdl/tdfd_ram.sv
hdl/tdfd_scale.sv
hdl/toggle_delta_frame_decoder_top.sv
hdl/tdfd_checker.sv
tb/sv/toggle_delta_frame_decoder_checker.sv
tb/sv/toggle_delta_frame_decoder_top_tb.sv
